>>> hdl/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg
// Shared types and constants of the toroidal life board engine.
// ----------------------------------------------------------------------------
package lag_pkg;

   localparam int ROW_W   = 6;   // row index field
   localparam int CELLS_W = 64;  // cell bits carried on the streams
   localparam int DIM_W   = 7;   // board_width / board_height registers
   localparam int REQ_W   = 2;   // request kind in tuser
   localparam int TDATA_W = 72;  // row index + cells, padded to bytes
   localparam int CSR_ADDR_W = 1;

   localparam logic [DIM_W-1:0] DIM_MIN   = 7'd8;
   localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

   localparam logic [CSR_ADDR_W-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEIGHT = 1'b1;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD = 2'd0,
      REQ_STEP = 2'd1,
      REQ_EMIT = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load_en;
      logic shift_en;
      logic tail;
   } cell_ctrl_type;

endpackage

>>> hdl/lag_row_cell.sv
// ----------------------------------------------------------------------------
// lag_row_cell
// One board row register in the rotating row chain.
// ----------------------------------------------------------------------------
module lag_row_cell
   import lag_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctrl_type    ctrl,
   input  logic [WIDTH-1:0] load_row,
   input  logic [WIDTH-1:0] neighbor_row,
   input  logic [WIDTH-1:0] feed_row,
   output logic [WIDTH-1:0] row_q
);

   logic [WIDTH-1:0] row_ff;
   logic [WIDTH-1:0] row_in;

   always_comb begin
      row_in = row_ff;
      if (ctrl.load_en) begin
         row_in = load_row;
      end else if (ctrl.shift_en) begin
         // the tail of the active board takes the row coming back from the head
         row_in = ctrl.tail ? feed_row : neighbor_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_q = row_ff;

endmodule

>>> hdl/lag_row_rule.sv
// ----------------------------------------------------------------------------
// lag_row_rule
// Next generation of one row from a three-row window, wrapping at the width.
// ----------------------------------------------------------------------------
module lag_row_rule
   import lag_pkg::*;
#(
   parameter int MAX_COLS = 64
) (
   input  logic [MAX_COLS-1:0] above,
   input  logic [MAX_COLS-1:0] here,
   input  logic [MAX_COLS-1:0] below,
   input  logic [DIM_W-1:0]    act_w,
   output logic [MAX_COLS-1:0] next_row
);

   localparam int CIDX_W = $clog2(MAX_COLS);

   logic [DIM_W-1:0]  w_minus;
   logic [CIDX_W-1:0] wl;
   logic              a_edge;
   logic              h_edge;
   logic              b_edge;

   assign w_minus = act_w - 7'd1;
   assign wl      = w_minus[CIDX_W-1:0];
   // rightmost active column of each row, the left neighbor of column zero
   assign a_edge  = above[wl];
   assign h_edge  = here[wl];
   assign b_edge  = below[wl];

   genvar c;
   generate
      for (c = 0; c < MAX_COLS; c++) begin : g_col
         localparam int LC = (c == 0) ? 0 : c - 1;
         localparam int RC = (c == MAX_COLS - 1) ? 0 : c + 1;
         logic       at_edge;
         logic       al, ar, hl, hr, bl, br;
         logic [3:0] nsum;

         assign at_edge = (CIDX_W'(c) == wl);
         assign al = (c == 0) ? a_edge : above[LC];
         assign hl = (c == 0) ? h_edge : here[LC];
         assign bl = (c == 0) ? b_edge : below[LC];
         assign ar = at_edge ? above[0] : above[RC];
         assign hr = at_edge ? here[0]  : here[RC];
         assign br = at_edge ? below[0] : below[RC];

         assign nsum = 4'(al) + 4'(above[c]) + 4'(ar) + 4'(hl) + 4'(hr)
                     + 4'(bl) + 4'(below[c]) + 4'(br);

         assign next_row[c] = (DIM_W'(c) < act_w)
                            && ((nsum == 4'd3) || ((nsum == 4'd2) && here[c]));
      end
   endgenerate

endmodule

>>> hdl/life_automaton_generation_step_top.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_step_top
// Toroidal life board: row loads, generation steps and board readout.
// ----------------------------------------------------------------------------
// Requests arrive on req_* (tuser = request kind, tdata = row index and row
// cells). A load writes one row and returns nothing. A step advances the
// board one generation and streams every active row on rsp_*; an emit
// streams the rows unchanged. rsp_tlast marks the final row. Board size is
// to be set over csr_* only while the block is idle; the block itself does
// not enforce this. The board lives in a chain of row registers that
// rotates one row per cycle through a single row rule unit; each rotation
// produces one result row. A step first captures the wrap rows in a
// prepare state, then rotates the rows out; an emit skips the prepare
// state. Requests are taken one at a time. A stall on rsp_tready halts
// the rotation; the result register holds its transaction until taken.
// Reset clears the board to all dead and sets the width and height to 64.
// ----------------------------------------------------------------------------
module life_automaton_generation_step_top
   import lag_pkg::*;
#(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TDATA_W-1:0]    req_tdata,   // row_index[5:0], row_cells[69:6]
   input  logic [REQ_W-1:0]      req_tuser,   // req_type[1:0]
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TDATA_W-1:0]    rsp_tdata,   // out_row[5:0], out_cells[69:6]
   output logic                  rsp_tlast,
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [DIM_W-1:0]      csr_wdata
);

   state_type state_ff, state_in;

   logic [DIM_W-1:0]    width_ff;
   logic [DIM_W-1:0]    height_ff;
   logic                step_ff;
   logic [ROW_W-1:0]    k_ff;
   logic [MAX_COLS-1:0] prev_ff;
   logic [MAX_COLS-1:0] saved0_ff;
   logic                rsp_valid_ff;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic [MAX_COLS-1:0] rsp_cells_ff;
   logic                rsp_last_ff;

   logic [DIM_W-1:0]    act_w;
   logic [DIM_W-1:0]    act_h;
   logic [DIM_W-1:0]    h_last;
   logic [MAX_COLS-1:0] wmask;
   logic                req_fire;
   req_kind_type        req_kind;
   logic [ROW_W-1:0]    req_row;
   logic [MAX_COLS-1:0] req_cells;
   logic                run_adv;
   logic                prep;
   logic                at_last;
   logic [MAX_COLS-1:0] row_q [MAX_ROWS];
   logic [MAX_ROWS-1:0] tail_sel;
   logic [MAX_COLS-1:0] tail_row;
   logic [MAX_COLS-1:0] below_row;
   logic [MAX_COLS-1:0] new_row;
   logic [MAX_COLS-1:0] feed_row;

   // active size, saturated to the supported range
   always_comb begin
      act_w = width_ff;
      if (width_ff < DIM_MIN) begin
         act_w = DIM_MIN;
      end else if (width_ff > DIM_W'(MAX_COLS)) begin
         act_w = DIM_W'(MAX_COLS);
      end
      act_h = height_ff;
      if (height_ff < DIM_MIN) begin
         act_h = DIM_MIN;
      end else if (height_ff > DIM_W'(MAX_ROWS)) begin
         act_h = DIM_W'(MAX_ROWS);
      end
   end

   assign h_last = act_h - 7'd1;

   genvar c;
   generate
      for (c = 0; c < MAX_COLS; c++) begin : g_mask
         assign wmask[c] = (DIM_W'(c) < act_w);
      end
   endgenerate

   assign req_fire  = req_tvalid && req_tready;
   assign req_kind  = req_kind_type'(req_tuser);
   assign req_row   = req_tdata[ROW_W-1:0];
   assign req_cells = req_tdata[ROW_W +: MAX_COLS] & wmask;
   assign at_last   = (k_ff == h_last[ROW_W-1:0]);

   // row chain
   genvar i;
   generate
      for (i = 0; i < MAX_ROWS; i++) begin : g_row
         cell_ctrl_type       ctrl;
         logic [MAX_COLS-1:0] neighbor;

         assign ctrl.load_en  = req_fire && (req_kind == REQ_LOAD)
                              && (req_row == ROW_W'(i)) && (DIM_W'(i) < act_h);
         assign ctrl.shift_en = run_adv && (DIM_W'(i) < act_h);
         assign ctrl.tail     = (DIM_W'(i) == h_last);
         assign tail_sel[i]   = ctrl.tail;

         if (i == MAX_ROWS - 1) begin : g_end
            assign neighbor = feed_row;
         end else begin : g_mid
            assign neighbor = row_q[i+1];
         end

         lag_row_cell #(
            .WIDTH (MAX_COLS)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (ctrl),
            .load_row     (req_cells),
            .neighbor_row (neighbor),
            .feed_row     (feed_row),
            .row_q        (row_q[i])
         );
      end
   endgenerate

   // last active row, captured once before a step as the row above row zero
   always_comb begin
      tail_row = '0;
      for (int r = 0; r < MAX_ROWS; r++) begin
         tail_row = tail_row | (row_q[r] & {MAX_COLS{tail_sel[r]}});
      end
   end

   // the chain already holds the new row zero once the last row is reached
   assign below_row = at_last ? saved0_ff : row_q[1];

   lag_row_rule #(
      .MAX_COLS (MAX_COLS)
   ) u_rule (
      .above    (prev_ff),
      .here     (row_q[0]),
      .below    (below_row),
      .act_w    (act_w),
      .next_row (new_row)
   );

   assign feed_row = step_ff ? new_row : row_q[0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  REQ_STEP: state_in = ST_PREP;
                  REQ_EMIT: state_in = ST_RUN;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_PREP: state_in = ST_RUN;
         ST_RUN: begin
            if (run_adv && at_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      prep       = 1'b0;
      run_adv    = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_PREP: prep       = 1'b1;
         ST_RUN:  run_adv    = !rsp_valid_ff || rsp_tready;
         default: req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= DIM_RESET;
         height_ff    <= DIM_RESET;
         step_ff      <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_WIDTH:  width_ff  <= csr_wdata;
               CSR_HEIGHT: height_ff <= csr_wdata;
               default:    width_ff  <= width_ff;
            endcase
         end
         if (req_fire) begin
            step_ff <= (req_kind == REQ_STEP);
            k_ff    <= '0;
         end else if (run_adv) begin
            k_ff <= k_ff + 6'd1;
         end
         if (run_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // window rows and result payload
   always_ff @(posedge clock) begin
      if (prep) begin
         prev_ff   <= tail_row;
         saved0_ff <= row_q[0];
      end else if (run_adv) begin
         prev_ff <= row_q[0];
      end
      if (run_adv) begin
         rsp_row_ff   <= k_ff;
         rsp_cells_ff <= feed_row & wmask;
         rsp_last_ff  <= at_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(TDATA_W - ROW_W - CELLS_W){1'b0}},
                        CELLS_W'(rsp_cells_ff), rsp_row_ff};

endmodule

>>> hdl/lag_checker.sv
// ----------------------------------------------------------------------------
// lag_checker
// Port-level checks of the life board engine, bound to the top level.
// ----------------------------------------------------------------------------
module lag_checker
   import lag_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tready,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [TDATA_W-1:0]    rsp_tdata,
   input  logic                  rsp_tlast
);

   // stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // no new request while a board readout is still in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken in the middle of a readout");

   // the final row is never below the minimum board height
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[ROW_W-1:0] >= ROW_W'(DIM_MIN - 7'd1))
      else $error("last row index below minimum height");

   // reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind life_automaton_generation_step_top lag_checker u_lag_checker (.*);

>>> tb/sv/life_automaton_generation_step_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_automaton_generation_step_top_test
// Self-checking bench for the toroidal life board engine.
// ----------------------------------------------------------------------------
// Row loads, generation steps and board readouts go in on the request stream.
// A behavioral copy of the board predicts every row that comes back on the
// result stream; the rows are compared field by field in order. Board sizes
// are changed between phases, including the saturating ones outside 8..64.
// Both stream sides idle in random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
module life_automaton_generation_step_top_test;
   import lag_pkg::*;

   localparam int                 BOARD_DEPTH   = 64;
   localparam int                 PAD_W         = TDATA_W - CELLS_W - ROW_W;
   localparam logic [REQ_W-1:0]   REQ_UNKNOWN   = 2'd3;
   localparam int unsigned        BIRTH_COUNT   = 3;
   localparam int unsigned        KEEP_COUNT    = 2;
   localparam int unsigned        SETTLE_CYCLES = 8;
   localparam int unsigned        TAIL_CYCLES   = 80;
   localparam int unsigned        RANDOM_END    = 350;
   localparam int unsigned        TOTAL_ITEMS   = 400;

   typedef struct packed {
      logic [ROW_W-1:0]   row_no;
      logic [CELLS_W-1:0] cells;
      logic               is_last;
   } board_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata;   // row_index[5:0], row_cells[69:6]
   logic [REQ_W-1:0]      req_tuser;   // req_type[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [TDATA_W-1:0]    rsp_tdata;   // out_row[5:0], out_cells[69:6]
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [DIM_W-1:0]      csr_wdata;

   // board model
   logic [CELLS_W-1:0] board_model [BOARD_DEPTH];
   logic [DIM_W-1:0]   model_width;
   logic [DIM_W-1:0]   model_height;

   board_row_type expected_rows [$];
   board_row_type next_expected;
   int unsigned error_count;
   int unsigned request_count;
   bit          sender_gaps;
   bit          receiver_stalls;
   int unsigned stall_left;

   life_automaton_generation_step_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // board model
   // ------------------------------------------------------------------------
   function automatic int unsigned live_cols();
      if (model_width < DIM_MIN) return 32'(DIM_MIN);
      if (model_width > 7'd64) return 64;
      return 32'(model_width);
   endfunction

   function automatic int unsigned live_rows();
      if (model_height < DIM_MIN) return 32'(DIM_MIN);
      if (model_height > 7'd64) return 64;
      return 32'(model_height);
   endfunction

   function automatic logic [CELLS_W-1:0] col_mask(input int unsigned w);
      if (w >= CELLS_W) return '1;
      return (64'd1 << w) - 64'd1;
   endfunction

   function automatic logic [CELLS_W-1:0] evolve_row(input logic [CELLS_W-1:0] above,
                                                     input logic [CELLS_W-1:0] here,
                                                     input logic [CELLS_W-1:0] below,
                                                     input int unsigned w);
      logic [CELLS_W-1:0] nxt;
      int unsigned        lf;
      int unsigned        rt;
      int unsigned        n;
      nxt = '0;
      for (int unsigned c = 0; c < w; c++) begin
         lf = (c == 0) ? w - 1 : c - 1;
         rt = (c + 1 == w) ? 0 : c + 1;
         n  = $countones({above[lf], above[c], above[rt], here[lf], here[rt],
                          below[lf], below[c], below[rt]});
         if (n == BIRTH_COUNT) nxt[c] = 1'b1;
         else if (n == KEEP_COUNT) nxt[c] = here[c];
      end
      return nxt;
   endfunction

   function automatic void advance_generation();
      int unsigned        w;
      int unsigned        h;
      logic [CELLS_W-1:0] top_old;
      logic [CELLS_W-1:0] prev;
      logic [CELLS_W-1:0] here;
      logic [CELLS_W-1:0] below;
      w       = live_cols();
      h       = live_rows();
      top_old = board_model[0];
      prev    = board_model[h-1];
      for (int unsigned y = 0; y < h; y++) begin
         here  = board_model[y];
         below = (y + 1 == h) ? top_old : board_model[y+1];
         board_model[y] = evolve_row(prev, here, below, w) & col_mask(w);
         prev = here;
      end
   endfunction

   function automatic void queue_board_rows();
      int unsigned        h;
      logic [CELLS_W-1:0] m;
      board_row_type      r;
      h = live_rows();
      m = col_mask(live_cols());
      for (int unsigned y = 0; y < h; y++) begin
         r.row_no  = y[ROW_W-1:0];
         r.cells   = board_model[y] & m;
         r.is_last = (y + 1 == h);
         expected_rows.push_back(r);
      end
   endfunction

   function automatic void predict_request(input logic [REQ_W-1:0] kind,
                                           input logic [ROW_W-1:0] row,
                                           input logic [CELLS_W-1:0] cells);
      case (kind)
         REQ_LOAD: begin
            if (row < live_rows()) board_model[row] = cells & col_mask(live_cols());
         end
         REQ_STEP: begin
            advance_generation();
            queue_board_rows();
         end
         REQ_EMIT: queue_board_rows();
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [CELLS_W-1:0] random_cells();
      logic [CELLS_W-1:0] a;
      logic [CELLS_W-1:0] b;
      logic [CELLS_W-1:0] c;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return a & b & c;
         1: return a & b;
         2: return a;
         3: return a | b;
         4: return 64'd1 << $urandom_range(0, 63);
         default: return ($urandom_range(0, 1) == 0) ? '0 : '1;
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] random_dimension();
      case ($urandom_range(0, 6))
         0: return DIM_MIN;
         1: return 7'd64;
         2: return DIM_W'($urandom_range(0, 7));
         3: return DIM_W'($urandom_range(65, 127));
         default: return DIM_W'($urandom_range(8, 64));
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [CELLS_W-1:0] want,
                                  input logic [CELLS_W-1:0] got);
      $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
      error_count++;
   endtask

   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [ROW_W-1:0] row,
                               input logic [CELLS_W-1:0] cells);
      int unsigned gap;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{PAD_W{1'b0}}, cells, row};
      do @(posedge clock); while (!req_tready);
      predict_request(kind, row, cells);
      request_count++;
   endtask

   // sender goes quiet until every predicted row is back, then lets the
   // block settle since loads and unknown codes leave nothing to wait on
   task automatic wait_board_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [DIM_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic write_board_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      wait_board_drained();
      write_register(CSR_WIDTH, w);
      model_width = w;
      write_register(CSR_HEIGHT, h);
      model_height = h;
   endtask

   // mixed transaction on a board that already has content
   task automatic send_random_request();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) send_request(REQ_STEP, ROW_W'($urandom), random_cells());
      else if (roll < 50) send_request(REQ_EMIT, ROW_W'($urandom), random_cells());
      else if (roll < 85) send_request(REQ_LOAD, ROW_W'($urandom_range(0, live_rows() - 1)),
                                       random_cells());
      else if (roll < 95) send_request(REQ_LOAD, ROW_W'($urandom_range(0, 63)),
                                       random_cells());
      else send_request(REQ_UNKNOWN, ROW_W'($urandom), random_cells());
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_reset_board();
      send_request(REQ_EMIT, '0, '0);
      send_request(REQ_UNKNOWN, '1, '1);
   endtask

   // glider straddling the corner plus a full row, full size board
   task automatic test_wrap_glider();
      send_request(REQ_LOAD, 6'd62, 64'h0000_0000_0000_0001);
      send_request(REQ_LOAD, 6'd63, 64'h0000_0000_0000_0002);
      send_request(REQ_LOAD, 6'd0, 64'h8000_0000_0000_0003);
      send_request(REQ_LOAD, 6'd31, '1);
      send_request(REQ_STEP, '0, '0);
      send_request(REQ_STEP, '1, '1);
      send_request(REQ_EMIT, '0, '0);
   endtask

   task automatic test_min_board();
      write_board_size(DIM_MIN, DIM_MIN);
      send_request(REQ_LOAD, 6'd9, '1);           // beyond height, dropped
      send_request(REQ_LOAD, 6'd7, '1);           // upper bits forced dead
      send_request(REQ_LOAD, 6'd0, 64'h0000_0000_0000_0083);  // blinker across wrap
      send_request(REQ_STEP, '0, '0);
      send_request(REQ_STEP, '0, '0);
      send_request(REQ_EMIT, '0, '0);
   endtask

   // rows past the active height must survive a step untouched
   task automatic test_kept_rows();
      write_board_size(7'd64, 7'd64);
      send_request(REQ_LOAD, 6'd50, random_cells());
      send_request(REQ_LOAD, 6'd40, {$urandom, $urandom});
      write_board_size(7'd64, 7'd16);
      send_request(REQ_STEP, '0, '0);
      write_board_size(7'd64, 7'd64);
      send_request(REQ_EMIT, '0, '0);
   endtask

   task automatic test_dimension_saturation();
      write_board_size(7'd0, 7'd127);
      send_request(REQ_EMIT, '0, '0);
      write_board_size(7'd127, 7'd7);
      send_request(REQ_LOAD, 6'd8, '1);
      send_request(REQ_STEP, '0, '0);
      write_board_size(7'd65, 7'd0);
      send_request(REQ_STEP, '0, '0);
   endtask

   task automatic test_drain_pause();
      write_board_size(7'd20, 7'd12);
      for (int unsigned y = 0; y < 12; y++) send_request(REQ_LOAD, ROW_W'(y), random_cells());
      send_request(REQ_STEP, '0, '0);
      wait_board_drained();
      send_request(REQ_STEP, '0, '0);
      send_request(REQ_EMIT, '0, '0);
   endtask

   task automatic test_random_boards();
      while (request_count < RANDOM_END) begin
         write_board_size(random_dimension(), random_dimension());
         sender_gaps     = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(4, 14))
            send_request(REQ_LOAD, ROW_W'($urandom_range(0, live_rows() - 1)),
                         random_cells());
         repeat ($urandom_range(4, 12)) send_random_request();
         if ($urandom_range(0, 4) == 0) wait_board_drained();
      end
   endtask

   task automatic test_quiet_tail();
      write_board_size(random_dimension(), random_dimension());
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      while (request_count < TOTAL_ITEMS) send_random_request();
   endtask

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rows.size() == 0) begin
            report_mismatch("unexpected result row", '0, CELLS_W'(rsp_tdata[ROW_W-1:0]));
         end else begin
            next_expected = expected_rows.pop_front();
            if (rsp_tdata[ROW_W-1:0] !== next_expected.row_no)
               report_mismatch("out_row", CELLS_W'(next_expected.row_no),
                               CELLS_W'(rsp_tdata[ROW_W-1:0]));
            if (rsp_tdata[ROW_W +: CELLS_W] !== next_expected.cells)
               report_mismatch("out_cells", next_expected.cells, rsp_tdata[ROW_W +: CELLS_W]);
            if (rsp_tlast !== next_expected.is_last)
               report_mismatch("last_row", CELLS_W'(next_expected.is_last),
                               CELLS_W'(rsp_tlast));
         end
      end
   end

   // receiver backpressure in bursts
   initial begin
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 7) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #8_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = REQ_LOAD;
      csr_we          = 1'b0;
      csr_addr        = CSR_WIDTH;
      csr_wdata       = DIM_RESET;
      error_count     = 0;
      request_count   = 0;
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      model_width     = DIM_RESET;
      model_height    = DIM_RESET;
      for (int i = 0; i < BOARD_DEPTH; i++) board_model[i] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_board();
      test_wrap_glider();
      test_min_board();
      test_kept_rows();
      test_dimension_saturation();
      test_drain_pause();
      test_random_boards();
      test_quiet_tail();

      wait_board_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
